[sv/kvfp_pkg.sv]
// Shared types and constants for the key/value frame parser.
// Holds byte codes, result kinds and the queue entry type; no dependencies.
package kvfp_pkg;

	// Result kinds
	localparam logic [1:0] KIND_START = 2'd0;
	localparam logic [1:0] KIND_VALUE = 2'd1;
	localparam logic [1:0] KIND_END   = 2'd2;

	// Byte codes
	localparam logic [7:0] SEP_FIRST  = 8'hC0;
	localparam logic [7:0] SEP_SECOND = 8'h80;
	localparam logic [7:0] NINE_CHAR  = 8'h39;
	localparam logic [7:0] MAIL_MARK  = 8'h01;
	localparam logic [7:0] NUL_CHAR   = 8'h00;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_CR      = 8'h0D;

	// Key magnitude limits
	localparam logic [31:0] MAG_CAP = 32'h8000_0000;
	localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;

	// Defaults
	localparam int KEY_BUFFER_DEF = 64;
	localparam int QUEUE_DEPTH    = 4;

	// Results caused by one input word: a first result, and optionally a pair end after it
	typedef struct packed {
		logic [1:0]        kind;
		logic signed [31:0] key;
		logic [7:0]        value;
		logic              two;
	} kvfp_entry_t;

	// Queue status seen by the top level and the back part
	typedef struct packed {
		logic full;
		logic empty;
	} kvfp_qstat_t;

endpackage

[sv/kvfp_front.sv]
// Front part: accepts body bytes, runs the pair parser and key conversion.
// Depends on kvfp_pkg; produces one queue entry per byte that causes results.
module kvfp_front import kvfp_pkg::*; #(
	parameter int KEY_BUFFER = KEY_BUFFER_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        take,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        push,
	output kvfp_entry_t entry
);

	localparam int KLW = $clog2(KEY_BUFFER);
	localparam logic [KLW-1:0] KEY_MAX = KLW'(KEY_BUFFER - 1);

	typedef enum logic [2:0] {
		PH_KEY, PH_NULSKIP, PH_VALUE, PH_DROP_A, PH_DROP_B
	} phase_t;

	typedef enum logic [1:0] {
		NP_SPACE, NP_SIGN, NP_DIGITS, NP_DONE
	} nphase_t;

	logic [7:0]     held_byte_q, held_byte_d;
	logic           held_valid_q, held_valid_d;
	phase_t         phase_q, phase_d;
	logic           pair_start_q, pair_start_d;
	logic           pkt_start_q, pkt_start_d;
	logic           nine_q, nine_d;
	logic [KLW-1:0] klen_q, klen_d;
	logic [31:0]    mag_q, mag_d;
	logic           neg_q, neg_d;
	nphase_t        nphase_q, nphase_d;
	logic           mail_q, mail_d;

	// magnitude times ten plus digit, saturated at 2^31
	function automatic logic [31:0] add_digit(input logic [31:0] mag, input logic [7:0] c);
		logic [35:0] m;
		m = ({4'b0, mag} << 3) + ({4'b0, mag} << 1) + 36'(c - CH_ZERO);
		return (m > 36'(MAG_CAP)) ? MAG_CAP : m[31:0];
	endfunction

	// Next state and results for the word on the input
	always_comb begin
		logic [7:0]  h;
		logic        sep;
		logic        consumed;
		logic        is_digit;
		logic        is_space;
		logic [31:0] keyv;

		held_byte_d  = held_byte_q;
		held_valid_d = held_valid_q;
		phase_d      = phase_q;
		pair_start_d = pair_start_q;
		pkt_start_d  = 1'b0;
		nine_d       = pkt_start_q ? (data_byte == NINE_CHAR) : nine_q;
		klen_d       = klen_q;
		mag_d        = mag_q;
		neg_d        = neg_q;
		nphase_d     = nphase_q;
		mail_d       = mail_q;
		push         = 1'b0;
		entry        = '0;
		consumed     = 1'b0;
		h            = held_byte_q;
		sep          = (held_byte_q == SEP_FIRST) && (data_byte == SEP_SECOND);
		is_digit     = (h >= CH_ZERO) && (h <= CH_NINE);
		is_space     = (h == CH_SPACE) || ((h >= CH_TAB) && (h <= CH_CR));
		keyv         = neg_q ? (32'd0 - mag_q) : ((mag_q > POS_MAX) ? POS_MAX : mag_q);

		// held byte, classified with the incoming byte as lookahead
		if (held_valid_q) begin
			held_valid_d = 1'b0;
			if (phase_q == PH_KEY && pair_start_q) begin
				pair_start_d = 1'b0;
				mail_d       = 1'b0;
				if (h == NUL_CHAR) begin
					phase_d = PH_NULSKIP;
				end
			end
			case (phase_d)
				PH_KEY: begin
					if (sep) begin
						consumed = 1'b1;
						if (klen_q != '0 && klen_q < KEY_MAX) begin
							push        = 1'b1;
							entry.kind  = KIND_START;
							entry.key   = keyv;
							phase_d     = PH_VALUE;
						end else begin
							phase_d = PH_DROP_A;
						end
					end else if (klen_q < KEY_MAX) begin
						klen_d = klen_q + 1'b1;
						// strtol-style conversion, one character a word
						case (nphase_q)
							NP_SPACE: begin
								if (!is_space) begin
									if (h == CH_PLUS || h == CH_MINUS) begin
										neg_d    = (h == CH_MINUS);
										nphase_d = NP_SIGN;
									end else if (is_digit) begin
										mag_d    = add_digit(mag_q, h);
										nphase_d = NP_DIGITS;
									end else begin
										nphase_d = NP_DONE;
									end
								end
							end
							NP_SIGN, NP_DIGITS: begin
								if (is_digit) begin
									mag_d    = add_digit(mag_q, h);
									nphase_d = NP_DIGITS;
								end else begin
									nphase_d = NP_DONE;
								end
							end
							default: ;
						endcase
					end
				end
				PH_NULSKIP: begin
					if (sep) begin
						consumed     = 1'b1;
						phase_d      = PH_KEY;
						pair_start_d = 1'b1;
						klen_d       = '0;
						mag_d        = '0;
						neg_d        = 1'b0;
						nphase_d     = NP_SPACE;
						mail_d       = 1'b0;
					end
				end
				PH_VALUE: begin
					push = 1'b1;
					if (sep) begin
						consumed     = 1'b1;
						entry.kind   = KIND_END;
						phase_d      = PH_KEY;
						pair_start_d = 1'b1;
						klen_d       = '0;
						mag_d        = '0;
						neg_d        = 1'b0;
						nphase_d     = NP_SPACE;
						mail_d       = 1'b1;
					end else begin
						entry.kind  = KIND_VALUE;
						entry.value = h;
					end
				end
				default: ;
			endcase
		end

		// bytes dropped after a rejected key, and the mail marker
		if (!consumed) begin
			if (phase_d == PH_DROP_A) begin
				phase_d  = PH_DROP_B;
				consumed = 1'b1;
			end else if (phase_d == PH_DROP_B) begin
				consumed     = 1'b1;
				phase_d      = PH_KEY;
				pair_start_d = 1'b1;
				klen_d       = '0;
				mag_d        = '0;
				neg_d        = 1'b0;
				nphase_d     = NP_SPACE;
				mail_d       = 1'b1;
			end else if (phase_d == PH_KEY && pair_start_d && mail_d) begin
				mail_d = 1'b0;
				if (nine_d && data_byte == MAIL_MARK) begin
					consumed = 1'b1;
				end
			end
		end

		if (!consumed && !last_byte) begin
			held_byte_d  = data_byte;
			held_valid_d = 1'b1;
		end

		// end of body: close an open value, then back to reset state
		if (last_byte) begin
			if (phase_d == PH_VALUE) begin
				if (push) begin
					entry.two = 1'b1;
				end else begin
					push       = 1'b1;
					entry.kind = KIND_END;
				end
			end
			held_byte_d  = '0;
			held_valid_d = 1'b0;
			phase_d      = PH_KEY;
			pair_start_d = 1'b1;
			pkt_start_d  = 1'b1;
			nine_d       = 1'b0;
			klen_d       = '0;
			mag_d        = '0;
			neg_d        = 1'b0;
			nphase_d     = NP_SPACE;
			mail_d       = 1'b0;
		end
	end

	// Parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_byte_q  <= '0;
			held_valid_q <= 1'b0;
			phase_q      <= PH_KEY;
			pair_start_q <= 1'b1;
			pkt_start_q  <= 1'b1;
			nine_q       <= 1'b0;
			klen_q       <= '0;
			mag_q        <= '0;
			neg_q        <= 1'b0;
			nphase_q     <= NP_SPACE;
			mail_q       <= 1'b0;
		end else if (take) begin
			held_byte_q  <= held_byte_d;
			held_valid_q <= held_valid_d;
			phase_q      <= phase_d;
			pair_start_q <= pair_start_d;
			pkt_start_q  <= pkt_start_d;
			nine_q       <= nine_d;
			klen_q       <= klen_d;
			mag_q        <= mag_d;
			neg_q        <= neg_d;
			nphase_q     <= nphase_d;
			mail_q       <= mail_d;
		end
	end

	a_pair_start_in_key: assert property (@(posedge clk) disable iff (!arst_n)
		pair_start_q |-> (phase_q == PH_KEY))
		else $error("pair start flagged outside key phase");

	a_body_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(take && last_byte) |=> (!held_valid_q && pkt_start_q && klen_q == '0))
		else $error("state not cleared after final word");

	a_mag_capped: assert property (@(posedge clk) disable iff (!arst_n)
		mag_q <= MAG_CAP)
		else $error("key magnitude beyond saturation limit");

endmodule

[sv/kvfp_queue.sv]
// Short queue between the parser front and the output back part.
// Depends on kvfp_pkg; one entry carries all results of one input word.
module kvfp_queue import kvfp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  kvfp_entry_t wr_entry,
	input  logic        pop,
	output kvfp_entry_t rd_entry,
	output kvfp_qstat_t stat
);

	localparam int PW = $clog2(QUEUE_DEPTH);

	kvfp_entry_t   entries_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   count_q;

	assign stat.full  = (count_q == (PW+1)'(QUEUE_DEPTH));
	assign stat.empty = (count_q == '0);
	assign rd_entry   = entries_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= wr_entry;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && stat.full && !pop))
		else $error("write into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && stat.empty))
		else $error("read from empty queue");

endmodule

[sv/kvfp_back.sv]
// Back part: unpacks queue entries into single results in an output register.
// Depends on kvfp_pkg; a second result of an entry is always a pair end.
module kvfp_back import kvfp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  kvfp_entry_t        head,
	input  kvfp_qstat_t        stat,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         event_kind,
	output logic signed [31:0] key_number,
	output logic [7:0]         value_byte,
	output logic               run_end
);

	logic        valid_q;
	logic        second_q;
	logic        load;
	logic [1:0]  kind_q;
	logic [31:0] key_q;
	logic [7:0]  value_q;
	logic        run_end_q;

	// output register free or being emptied this cycle
	assign load = (!valid_q || !out_stall) && !stat.empty;
	assign pop  = load && (second_q || !head.two);

	assign out_valid  = valid_q;
	assign event_kind = kind_q;
	assign key_number = key_q;
	assign value_byte = value_q;
	assign run_end    = run_end_q;

	// Output register and position within the head entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			second_q  <= 1'b0;
			kind_q    <= KIND_START;
			key_q     <= '0;
			value_q   <= '0;
			run_end_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
			if (second_q) begin
				kind_q    <= KIND_END;
				key_q     <= '0;
				value_q   <= '0;
				run_end_q <= 1'b1;
				second_q  <= 1'b0;
			end else begin
				kind_q    <= head.kind;
				key_q     <= head.key;
				value_q   <= head.value;
				run_end_q <= !head.two;
				second_q  <= head.two;
			end
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	a_second_has_head: assert property (@(posedge clk) disable iff (!arst_n)
		second_q |-> !stat.empty)
		else $error("pending pair end without queue entry");

	a_second_after_first: assert property (@(posedge clk) disable iff (!arst_n)
		second_q |-> (valid_q && !run_end_q))
		else $error("pair end pending but first result closed the word");

endmodule

[sv/key_value_frame_parser_unit.sv]
// Key/value frame parser, top level.
// Depends on kvfp_pkg, kvfp_front, kvfp_queue and kvfp_back.
//
// Takes one packet body byte per cycle and gives pair start (with the decimal
// key), value byte and pair end results, one per cycle unless the receiver
// stalls. A byte is held in a one-byte lookahead register, so its results
// come out when the next byte arrives; a final byte may also close an open
// value. Input accept goes low only while the four-entry queue between the
// parser and the output register is full; each entry carries all results of
// one byte (one, or one plus a pair end), so a byte that causes two results
// gives them on the output one after the other. Results pass through the
// queue and the output register. There is no start-up sweep: the block
// takes bytes from the first cycle after reset.
module key_value_frame_parser_unit import kvfp_pkg::*; #(
	parameter int KEY_BUFFER = KEY_BUFFER_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         data_byte,
	input  logic               last_byte,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         event_kind,
	output logic signed [31:0] key_number,
	output logic [7:0]         value_byte,
	output logic               run_end
);

	logic        take;
	logic        push_raw;
	logic        pop;
	kvfp_entry_t wr_entry;
	kvfp_entry_t head;
	kvfp_qstat_t stat;

	assign in_stall = stat.full;
	assign take     = in_valid && !stat.full;

	kvfp_front #(
		.KEY_BUFFER (KEY_BUFFER)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.push      (push_raw),
		.entry     (wr_entry)
	);

	kvfp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push_raw && take),
		.wr_entry (wr_entry),
		.pop      (pop),
		.rd_entry (head),
		.stat     (stat)
	);

	kvfp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.stat       (stat),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.event_kind (event_kind),
		.key_number (key_number),
		.value_byte (value_byte),
		.run_end    (run_end)
	);

endmodule

[tb/testbench.sv]
// Self-checking testbench for key_value_frame_parser_unit.
// Depends on kvfp_pkg and the parser RTL; a built-in parser model predicts the results not
// typed by hand; random packets, after directed ones, run under varying gaps and stalls.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import kvfp_pkg::*;

	localparam int unsigned HALF_PERIOD = 10;
	localparam int unsigned RESET_CYCLES = 8;
	localparam int unsigned CYCLE_LIMIT = 300000;
	localparam int unsigned DRAIN_CYCLES = 32;
	localparam int unsigned RANDOM_WORDS = 1050;
	localparam int unsigned MODE_SPAN = 150;
	localparam int unsigned REPORT_LIMIT = 10;
	localparam int unsigned KEY_LIMIT = KEY_BUFFER_DEF - 1;
	localparam logic [63:0] NUM_BASE = 64'd10;

	// One result word of the parser
	typedef struct packed {
		logic [1:0]         kind;
		logic signed [31:0] key;
		logic [7:0]         value;
		logic               run_end;
	} pair_event_t;

	localparam pair_event_t NO_EVENT = '0;

	// Directed row: input word plus, where obvious, the results typed in by hand
	typedef struct packed {
		logic [7:0]  data;
		logic        fin;
		logic [1:0]  n_typed;
		pair_event_t ev_a;
		pair_event_t ev_b;
	} opening_row_t;

	typedef enum logic [2:0] {
		PARSE_KEY, PARSE_NULSKIP, PARSE_VALUE, PARSE_DROP_A, PARSE_DROP_B
	} parse_stage_t;

	typedef enum logic [1:0] {NUM_SPACE, NUM_SIGN, NUM_DIGITS, NUM_DONE} num_stage_t;

	typedef enum logic [1:0] {
		MODE_FREE, MODE_SENDER_GAPS, MODE_RECEIVER_STALLS, MODE_BOTH
	} load_mode_t;

	// Packets: mail marker, NUL-opened pair with two-word tail, empty key, key cut off
	localparam opening_row_t OPENING [28] = '{
		'{NINE_CHAR,  1'b0, 2'd0, NO_EVENT, NO_EVENT},
		'{SEP_FIRST,  1'b0, 2'd0, NO_EVENT, NO_EVENT},
		'{SEP_SECOND, 1'b0, 2'd1, '{KIND_START, 32'sd9, 8'h00, 1'b1}, NO_EVENT},
		'{8'hFF,      1'b0, 2'd0, NO_EVENT, NO_EVENT},
		'{SEP_FIRST,  1'b0, 2'd1, '{KIND_VALUE, 32'sd0, 8'hFF, 1'b1}, NO_EVENT},
		'{SEP_SECOND, 1'b0, 2'd1, '{KIND_END, 32'sd0, 8'h00, 1'b1}, NO_EVENT},
		'{MAIL_MARK,  1'b0, 2'd0, NO_EVENT, NO_EVENT},
		'{NUL_CHAR,   1'b1, 2'd0, NO_EVENT, NO_EVENT},
		'{NUL_CHAR,   1'b0, 2'd0, NO_EVENT, NO_EVENT},
		'{SEP_FIRST,  1'b0, 2'd0, NO_EVENT, NO_EVENT},
		'{SEP_SECOND, 1'b0, 2'd0, NO_EVENT, NO_EVENT},
		'{CH_PLUS,    1'b0, 2'd0, NO_EVENT, NO_EVENT},
		'{SEP_FIRST,  1'b0, 2'd0, NO_EVENT, NO_EVENT},
		'{SEP_SECOND, 1'b0, 2'd1, '{KIND_START, 32'sd0, 8'h00, 1'b1}, NO_EVENT},
		'{8'h76,      1'b0, 2'd0, NO_EVENT, NO_EVENT},
		'{8'hAA,      1'b1, 2'd2, '{KIND_VALUE, 32'sd0, 8'h76, 1'b0},
			'{KIND_END, 32'sd0, 8'h00, 1'b1}},
		'{SEP_FIRST,  1'b0, 2'd0, NO_EVENT, NO_EVENT},
		'{SEP_SECOND, 1'b0, 2'd0, NO_EVENT, NO_EVENT},
		'{8'h12,      1'b0, 2'd0, NO_EVENT, NO_EVENT},
		'{8'h34,      1'b0, 2'd0, NO_EVENT, NO_EVENT},
		'{CH_SPACE,   1'b0, 2'd0, NO_EVENT, NO_EVENT},
		'{CH_MINUS,   1'b0, 2'd0, NO_EVENT, NO_EVENT},
		'{8'h32,      1'b0, 2'd0, NO_EVENT, NO_EVENT},
		'{SEP_FIRST,  1'b0, 2'd0, NO_EVENT, NO_EVENT},
		'{SEP_SECOND, 1'b0, 2'd1, '{KIND_START, -32'sd2, 8'h00, 1'b1}, NO_EVENT},
		'{SEP_FIRST,  1'b1, 2'd1, '{KIND_END, 32'sd0, 8'h00, 1'b1}, NO_EVENT},
		'{8'h37,      1'b0, 2'd0, NO_EVENT, NO_EVENT},
		'{8'hFF,      1'b1, 2'd0, NO_EVENT, NO_EVENT}
	};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [7:0]         data_byte = 8'h00;
	logic               last_byte = 1'b0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [1:0]         event_kind;
	logic signed [31:0] key_number;
	logic [7:0]         value_byte;
	logic               run_end;

	// Parser model state
	logic [7:0]   la_byte;
	bit           la_full;
	parse_stage_t stage;
	bit           pair_fresh;
	bit           packet_fresh;
	bit           nine_first;
	int unsigned  key_len;
	logic [31:0]  key_mag;
	bit           key_neg;
	num_stage_t   num_stage;
	bit           mark_skip;

	pair_event_t  byte_events[$];
	pair_event_t  awaited[$];
	logic [7:0]   packet_bytes[$];

	load_mode_t   load_mode = MODE_FREE;
	int unsigned  gap_pct = 0;
	int unsigned  stall_pct = 0;
	int unsigned  cycle_count = 0;
	int unsigned  words_sent = 0;
	int unsigned  packets_sent = 0;
	int unsigned  results_seen = 0;
	int unsigned  starts_seen = 0;
	int unsigned  values_seen = 0;
	int unsigned  ends_seen = 0;
	int unsigned  faults = 0;

	key_value_frame_parser_unit uut (.*);

	always #(HALF_PERIOD) clk = ~clk;

	// ---- parser model ----

	task automatic start_pair(input bit mark);
		stage = PARSE_KEY;
		pair_fresh = 1'b1;
		key_len = 0;
		key_mag = '0;
		key_neg = 1'b0;
		num_stage = NUM_SPACE;
		mark_skip = mark;
	endtask

	task automatic clear_parser();
		la_byte = '0;
		la_full = 1'b0;
		packet_fresh = 1'b1;
		nine_first = 1'b0;
		start_pair(1'b0);
	endtask

	task automatic push_digit(input logic [7:0] c);
		logic [63:0] grown;
		grown = {32'd0, key_mag} * NUM_BASE + {56'd0, c - CH_ZERO};
		key_mag = (grown > {32'd0, MAG_CAP}) ? MAG_CAP : grown[31:0];
		num_stage = NUM_DIGITS;
	endtask

	task automatic add_event(input logic [1:0] kind, input logic [31:0] key,
			input logic [7:0] val);
		byte_events.push_back('{kind, key, val, 1'b0});
	endtask

	// Advance the model by one input word; its results land in byte_events
	task automatic parse_word(input logic [7:0] b, input bit fin);
		logic [7:0]  h;
		logic [31:0] kv;
		bit          sep;
		bit          taken;
		bit          digit;
		bit          space;
		taken = 1'b0;
		byte_events.delete();
		if (packet_fresh) begin
			nine_first = (b == NINE_CHAR);
			packet_fresh = 1'b0;
		end
		// held word resolved against the new one
		if (la_full) begin
			h = la_byte;
			sep = (h == SEP_FIRST) && (b == SEP_SECOND);
			la_full = 1'b0;
			if (stage == PARSE_KEY && pair_fresh) begin
				pair_fresh = 1'b0;
				mark_skip = 1'b0;
				if (h == NUL_CHAR)
					stage = PARSE_NULSKIP;
			end
			case (stage)
				PARSE_KEY: begin
					if (sep) begin
						taken = 1'b1;
						if (key_len >= 1 && key_len < KEY_LIMIT) begin
							kv = key_neg ? (32'd0 - key_mag) :
								((key_mag > POS_MAX) ? POS_MAX : key_mag);
							add_event(KIND_START, kv, 8'h00);
							stage = PARSE_VALUE;
						end else begin
							stage = PARSE_DROP_A;
						end
					end else if (key_len < KEY_LIMIT) begin
						// strtol-style conversion, one character at a time
						digit = (h >= CH_ZERO) && (h <= CH_NINE);
						space = (h == CH_SPACE) || (h >= CH_TAB && h <= CH_CR);
						case (num_stage)
							NUM_SPACE: begin
								if (!space) begin
									if (h == CH_PLUS || h == CH_MINUS) begin
										key_neg = (h == CH_MINUS);
										num_stage = NUM_SIGN;
									end else if (digit) begin
										push_digit(h);
									end else begin
										num_stage = NUM_DONE;
									end
								end
							end
							NUM_SIGN, NUM_DIGITS: begin
								if (digit)
									push_digit(h);
								else
									num_stage = NUM_DONE;
							end
							default: ;
						endcase
						key_len++;
					end
				end
				PARSE_NULSKIP: begin
					if (sep) begin
						taken = 1'b1;
						start_pair(1'b0);
					end
				end
				PARSE_VALUE: begin
					if (sep) begin
						taken = 1'b1;
						add_event(KIND_END, 32'd0, 8'h00);
						start_pair(1'b1);
					end else begin
						add_event(KIND_VALUE, 32'd0, h);
					end
				end
				default: ;
			endcase
		end
		// dropped words after a rejected key, and the mail marker
		if (!taken) begin
			if (stage == PARSE_DROP_A) begin
				stage = PARSE_DROP_B;
				taken = 1'b1;
			end else if (stage == PARSE_DROP_B) begin
				start_pair(1'b1);
				taken = 1'b1;
			end else if (stage == PARSE_KEY && pair_fresh && mark_skip) begin
				mark_skip = 1'b0;
				taken = nine_first && (b == MAIL_MARK);
			end
		end
		if (!taken && !fin) begin
			la_byte = b;
			la_full = 1'b1;
		end
		// end of body closes an open value and clears everything
		if (fin) begin
			if (stage == PARSE_VALUE)
				add_event(KIND_END, 32'd0, 8'h00);
			clear_parser();
		end
		if (byte_events.size() > 0)
			byte_events[byte_events.size() - 1].run_end = 1'b1;
	endtask

	task automatic await_model();
		foreach (byte_events[k])
			awaited.push_back(byte_events[k]);
	endtask

	// ---- stimulus ----

	function automatic logic [7:0] pick_byte(input int unsigned special_pct);
		if ($urandom_range(99) >= special_pct)
			return 8'($urandom_range(255));
		case ($urandom_range(5))
			0: return NUL_CHAR;
			1: return MAIL_MARK;
			2: return SEP_FIRST;
			3: return SEP_SECOND;
			4: return NINE_CHAR;
			default: return CH_MINUS;
		endcase
	endfunction

	task automatic push_sep();
		packet_bytes.push_back(SEP_FIRST);
		packet_bytes.push_back(SEP_SECOND);
	endtask

	// Mostly well-formed pairs with random content; the rest noise or cut short
	task automatic build_packet();
		int unsigned shape;
		int unsigned n;
		bit          mail;
		packet_bytes.delete();
		shape = $urandom_range(99);
		if (shape >= 80) begin
			n = $urandom_range(1, 16);
			repeat (n) packet_bytes.push_back(pick_byte(50));
		end else begin
			mail = ($urandom_range(2) == 0);
			if (mail)
				packet_bytes.push_back(NINE_CHAR);
			repeat ($urandom_range(1, 4)) begin
				shape = $urandom_range(99);
				if (shape < 8) begin
					// NUL-opened pair, skipped up to the separator
					packet_bytes.push_back(NUL_CHAR);
					repeat ($urandom_range(0, 3)) packet_bytes.push_back(pick_byte(0));
					push_sep();
				end else if (shape < 16) begin
					// empty key: separator, then two words that get dropped
					push_sep();
					repeat (2) packet_bytes.push_back(pick_byte(30));
				end else begin
					if (shape < 22) begin
						// key near the buffer length
						repeat ($urandom_range(60, 66))
							packet_bytes.push_back(($urandom_range(7) == 0) ? CH_SPACE :
								8'(CH_ZERO + $urandom_range(9)));
					end else begin
						repeat ($urandom_range(0, 2))
							packet_bytes.push_back(($urandom_range(6) == 6) ? CH_SPACE :
								8'(CH_TAB + $urandom_range(4)));
						if ($urandom_range(2) == 0)
							packet_bytes.push_back($urandom_range(1) ? CH_MINUS : CH_PLUS);
						n = ($urandom_range(4) == 0) ? $urandom_range(9, 12) :
							$urandom_range(0, 4);
						repeat (n) packet_bytes.push_back(8'(CH_ZERO + $urandom_range(9)));
						if ($urandom_range(5) == 0)
							packet_bytes.push_back(pick_byte(30));
					end
					push_sep();
					repeat ($urandom_range(0, 5)) packet_bytes.push_back(pick_byte(15));
					push_sep();
				end
				if (mail && $urandom_range(1))
					packet_bytes.push_back(MAIL_MARK);
			end
			// sometimes the body ends mid-key or mid-value
			if ($urandom_range(3) == 0)
				repeat ($urandom_range(1, 3)) void'(packet_bytes.pop_back());
		end
		// closing word, never content
		packet_bytes.push_back(pick_byte(20));
	endtask

	// Offer one word, wait for the handshake, then run the model on it
	task automatic send_word(input logic [7:0] b, input bit fin);
		while ($urandom_range(99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		last_byte <= fin;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		words_sent++;
		if (fin)
			packets_sent++;
		parse_word(b, fin);
	endtask

	// ---- checking ----

	task automatic note_fault(input string what, input pair_event_t want,
			input pair_event_t got);
		faults++;
		if (faults <= REPORT_LIMIT)
			$display({"%s at cycle %0d: want kind %0d key %0d value %02h end %0b,",
				" got kind %0d key %0d value %02h end %0b"},
				what, cycle_count, want.kind, want.key, want.value, want.run_end,
				got.kind, got.key, got.value, got.run_end);
	endtask

	// receiver stall
	always @(posedge clk)
		out_stall <= ($urandom_range(99) < stall_pct);

	// result word check against the oldest prediction
	always @(posedge clk) begin
		pair_event_t got;
		pair_event_t want;
		cycle_count++;
		if (arst_n && out_valid && !out_stall) begin
			got = '{event_kind, key_number, value_byte, run_end};
			results_seen++;
			case (got.kind)
				KIND_START: starts_seen++;
				KIND_VALUE: values_seen++;
				KIND_END: ends_seen++;
				default: ;
			endcase
			if (awaited.size() == 0) begin
				note_fault("unexpected result", NO_EVENT, got);
			end else begin
				want = awaited.pop_front();
				if (got !== want)
					note_fault("result mismatch", want, got);
			end
		end
		if (cycle_count > CYCLE_LIMIT) begin
			$display("run stopped after %0d cycles with %0d results outstanding",
				cycle_count, awaited.size());
			$display("key_value_frame_parser_unit: mismatch");
			$finish;
		end
	end

	// ---- main sequence ----

	initial begin
		int unsigned random_words;
		load_mode_t  next_mode;
		random_words = 0;
		clear_parser();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed packets
		foreach (OPENING[i]) begin
			send_word(OPENING[i].data, OPENING[i].fin);
			if (OPENING[i].n_typed == 0) begin
				await_model();
			end else begin
				awaited.push_back(OPENING[i].ev_a);
				if (OPENING[i].n_typed == 2)
					awaited.push_back(OPENING[i].ev_b);
			end
		end

		// random packets, load pattern changed every MODE_SPAN words at a packet boundary
		while (random_words < RANDOM_WORDS) begin
			next_mode = load_mode_t'((random_words / MODE_SPAN) % 4);
			if (next_mode != load_mode) begin
				// hold off until the pipeline is empty
				in_valid <= 1'b0;
				do @(posedge clk); while (awaited.size() != 0);
				load_mode = next_mode;
				case (load_mode)
					MODE_SENDER_GAPS: begin
						gap_pct = 81;
						stall_pct = 0;
					end
					MODE_RECEIVER_STALLS: begin
						gap_pct = 0;
						stall_pct = 81;
					end
					MODE_BOTH: begin
						gap_pct = 23;
						stall_pct = 23;
					end
					default: begin
						gap_pct = 0;
						stall_pct = 0;
					end
				endcase
			end
			build_packet();
			foreach (packet_bytes[i]) begin
				send_word(packet_bytes[i], i == packet_bytes.size() - 1);
				await_model();
				random_words++;
			end
		end

		// drain
		in_valid <= 1'b0;
		stall_pct = 0;
		do @(posedge clk); while (awaited.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d words in %0d packets under four load patterns, %0d cycles.",
			words_sent, packets_sent, cycle_count);
		$display("Checked %0d results: %0d pair starts, %0d value words, %0d pair ends; %0d faults.",
			results_seen, starts_seen, values_seen, ends_seen, faults);
		if (faults == 0 && awaited.size() == 0) begin
			$display("key_value_frame_parser_unit: match");
		end else begin
			$display("key_value_frame_parser_unit: mismatch");
		end
		$finish;
	end

endmodule

[sim.f]
sv/kvfp_pkg.sv
sv/kvfp_front.sv
sv/kvfp_queue.sv
sv/kvfp_back.sv
sv/key_value_frame_parser_unit.sv
tb/testbench.sv
